>>> rtl/dpb_pkg.sv
// ---------------------------------------------------------------------------
// dpb_pkg : shared types and constants for the depth back-projection unit
// Payload words, the job word passed from front to back, register indexes
// and the back-end state encoding.
// ---------------------------------------------------------------------------
package dpb_pkg;

    // default parameter values
    localparam int MAX_DIM_DEF    = 4096;
    localparam int DEPTH_FRAC_DEF = 16;

    // fixed field widths
    localparam int DEPTH_W  = 24;
    localparam int COLOUR_W = 8;
    localparam int FOCAL_W  = 16;
    localparam int DIM_W    = 13;
    localparam int POINT_W  = 32;
    localparam int OUT_FRAC = 16;          // fraction bits of point_x/point_y
    localparam int MAG_W    = 17;          // |16*pos - centre|
    localparam int PROD_W   = MAG_W + DEPTH_W;
    localparam int QUO_W    = POINT_W;

    // configuration port
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;

    localparam logic [FOCAL_W-1:0] FOCAL_X_RST  = 16'd8384;
    localparam logic [FOCAL_W-1:0] FOCAL_Y_RST  = 16'd8384;
    localparam logic [FOCAL_W-1:0] CENTER_X_RST = 16'd5120;
    localparam logic [FOCAL_W-1:0] CENTER_Y_RST = 16'd3840;
    localparam logic [DIM_W-1:0]   WIDTH_RST    = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RST   = 13'd480;
    localparam logic [DEPTH_W-1:0] DMIN_RST     = 24'd655;
    localparam logic [DEPTH_W-1:0] DMAX_RST     = 24'd655360;

    // saturation limits
    localparam logic [QUO_W-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] NEG_LIM = 32'h8000_0000;

    // job queue between front and back
    localparam int JOBQ_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_DEPTH_MIN,
        REG_DEPTH_MAX
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        logic [DEPTH_W-1:0]  depth_value;
        logic [COLOUR_W-1:0] blue_in;
        logic [COLOUR_W-1:0] green_in;
        logic [COLOUR_W-1:0] red_in;
        logic                frame_start;
    } t_pixel;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic [COLOUR_W-1:0]       red_out;
        logic [COLOUR_W-1:0]       green_out;
        logic [COLOUR_W-1:0]       blue_out;
        logic                      point_valid;
        logic                      frame_end;
    } t_point;

    typedef struct packed {
        logic [MAG_W-1:0]    mag_x;
        logic                neg_x;
        logic [MAG_W-1:0]    mag_y;
        logic                neg_y;
        logic [DEPTH_W-1:0]  depth;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                valid;
        logic                frame_end;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_jobq_stat;

endpackage

>>> rtl/dpb_front.sv
// ---------------------------------------------------------------------------
// dpb_front : pixel intake and classification
// Keeps the raster counters, range-checks depth, marks frame end and forms
// the signed offsets from the principal point.
// ---------------------------------------------------------------------------
module dpb_front
    import dpb_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_pixel             i_pixel,
    input  t_jobq_stat         i_q_stat,
    input  logic [FOCAL_W-1:0] i_center_x,
    input  logic [FOCAL_W-1:0] i_center_y,
    input  logic [DIM_W-1:0]   i_image_width,
    input  logic [DIM_W-1:0]   i_image_height,
    input  logic [DEPTH_W-1:0] i_depth_min,
    input  logic [DEPTH_W-1:0] i_depth_max,
    output logic               o_q_push,
    output t_job               o_job
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] col, row;
    logic [DIM_W-1:0] w_eff, h_eff, col_d, row_d;
    logic [MAG_W:0]   diff_x, diff_y;
    logic             accept;

    assign accept = i_push && !i_q_stat.full;
    assign o_q_push = accept;

    assign col = i_pixel.frame_start ? '0 : r_col;
    assign row = i_pixel.frame_start ? '0 : r_row;
    assign col_d = DIM_W'(col);
    assign row_d = DIM_W'(row);

    assign w_eff = (i_image_width == '0) ? DIM_W'(1) :
                   (i_image_width > MAX_DIM_V) ? MAX_DIM_V : i_image_width;
    assign h_eff = (i_image_height == '0) ? DIM_W'(1) :
                   (i_image_height > MAX_DIM_V) ? MAX_DIM_V : i_image_height;

    // 16*pos - centre, both in Q.4
    assign diff_x = (MAG_W+1)'(MAG_W'(col) << 4) - (MAG_W+1)'(i_center_x);
    assign diff_y = (MAG_W+1)'(MAG_W'(row) << 4) - (MAG_W+1)'(i_center_y);

    always_comb begin
        o_job.neg_x = diff_x[MAG_W];
        o_job.mag_x = diff_x[MAG_W] ? MAG_W'(-diff_x) : diff_x[MAG_W-1:0];
        o_job.neg_y = diff_y[MAG_W];
        o_job.mag_y = diff_y[MAG_W] ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];
        o_job.depth = i_pixel.depth_value;
        o_job.red   = i_pixel.red_in;
        o_job.green = i_pixel.green_in;
        o_job.blue  = i_pixel.blue_in;
        o_job.valid = (i_pixel.depth_value >= i_depth_min) &&
                      (i_pixel.depth_value <= i_depth_max);
        o_job.frame_end = (col_d == w_eff - DIM_W'(1)) &&
                          (row_d == h_eff - DIM_W'(1));
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_d + DIM_W'(1) >= w_eff) begin
                n_col = '0;
                if (row_d + DIM_W'(1) >= h_eff) begin
                    n_row = '0;
                end else begin
                    n_row = CNT_W'(row_d + DIM_W'(1));
                end
            end else begin
                n_col = CNT_W'(col_d + DIM_W'(1));
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // the last pixel of a frame always sends both counters home
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_job.frame_end) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after frame end");

endmodule

>>> rtl/dpb_jobq.sv
// ---------------------------------------------------------------------------
// dpb_jobq : short job queue between front and back
// Lets the intake run ahead of the dividers by a couple of words.
// ---------------------------------------------------------------------------
module dpb_jobq
    import dpb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_job,
    output t_jobq_stat o_stat
);

    localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    t_job             r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_stat.full  = (r_count == CNT_W'(JOBQ_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("job queue read while empty");

endmodule

>>> rtl/dpb_div.sv
// ---------------------------------------------------------------------------
// dpb_div : rounded, saturating projection divider
// Restoring division, one quotient bit per cycle, of offset*depth by focal
// length with round-half-up on the magnitude and signed Q15.16 clamp.
// ---------------------------------------------------------------------------
module dpb_div
    import dpb_pkg::*;
#(
    parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [PROD_W-1:0]         i_prod,
    input  logic [FOCAL_W-1:0]        i_focal,
    input  logic                      i_neg,
    output logic                      o_done,
    output logic signed [POINT_W-1:0] o_result
);

    localparam int SHL   = (DEPTH_FRAC_BITS < OUT_FRAC) ? OUT_FRAC - DEPTH_FRAC_BITS : 0;
    localparam int SHR   = (DEPTH_FRAC_BITS > OUT_FRAC) ? DEPTH_FRAC_BITS - OUT_FRAC : 0;
    localparam int NN_W  = PROD_W + SHL;
    localparam int D_W   = FOCAL_W + SHR + 1;   // twice the divisor
    localparam int M_W   = NN_W + 2;
    localparam int HI_W  = M_W - QUO_W;
    localparam int CMP_W = (HI_W > D_W) ? HI_W : D_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic [D_W-1:0]   two_d;
    logic [NN_W-1:0]  nn;
    logic [M_W-1:0]   m;
    logic [HI_W-1:0]  hi;
    logic             ovf;
    logic [D_W:0]     trial;
    logic             ge;
    logic [QUO_W-1:0] mag_sat;

    logic             r_busy, r_fin, r_done, r_ovf, r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [QUO_W-1:0] r_low;
    logic signed [POINT_W-1:0] r_result;

    // q = floor((2*N + D) / (2*D)), N and D aligned to Q.16
    assign two_d = D_W'({i_focal, 1'b0}) << SHR;
    assign nn    = NN_W'(i_prod) << SHL;
    assign m     = M_W'({nn, 1'b0}) + M_W'(two_d >> 1);
    assign hi    = m[M_W-1:QUO_W];
    assign ovf   = CMP_W'(hi) >= CMP_W'(two_d);

    assign trial = {r_rem, r_low[QUO_W-1]};
    assign ge    = trial >= {1'b0, two_d};

    always_comb begin
        if (r_neg) begin
            mag_sat = (r_ovf || r_low > NEG_LIM) ? NEG_LIM : r_low;
        end else begin
            mag_sat = (r_ovf || r_low[QUO_W-1]) ? POS_LIM : r_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= ovf;
            r_neg <= i_neg;
            r_rem <= ovf ? '0 : D_W'(hi);
            r_low <= m[QUO_W-1:0];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? D_W'(trial - {1'b0, two_d}) : D_W'(trial);
            r_low <= {r_low[QUO_W-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_fin) begin
            r_result <= r_neg ? $signed(QUO_W'(0) - mag_sat) : $signed(mag_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> rtl/dpb_back.sv
// ---------------------------------------------------------------------------
// dpb_back : projection engine and result register
// Takes jobs from the queue, multiplies offset by depth, runs both
// dividers side by side and holds the finished word for the consumer.
// ---------------------------------------------------------------------------
module dpb_back
    import dpb_pkg::*;
#(
    parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  t_jobq_stat         i_q_stat,
    output logic               o_job_pop,
    input  logic [FOCAL_W-1:0] i_focal_x,
    input  logic [FOCAL_W-1:0] i_focal_y,
    input  logic               i_pop,
    output logic               o_empty,
    output t_point             o_point
);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [PROD_W-1:0] r_prod_x, r_prod_y;
    logic        start, out_load;
    logic        done_x, done_y;
    logic signed [POINT_W-1:0] res_x, res_y;
    t_point      r_point;
    logic        r_out_vld;

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        start     = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_job_pop = 1'b1;
                    n_state   = i_job.valid ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                n_state = ST_START;
            end
            ST_START: begin
                start   = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (done_x) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_pop) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == ST_MUL) begin
            r_prod_x <= PROD_W'(r_job.mag_x) * PROD_W'(r_job.depth);
            r_prod_y <= PROD_W'(r_job.mag_y) * PROD_W'(r_job.depth);
        end
    end

    dpb_div #(
        .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
    ) u_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_prod   (r_prod_x),
        .i_focal  (i_focal_x),
        .i_neg    (r_job.neg_x),
        .o_done   (done_x),
        .o_result (res_x)
    );

    dpb_div #(
        .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
    ) u_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_prod   (r_prod_y),
        .i_focal  (i_focal_y),
        .i_neg    (r_job.neg_y),
        .o_done   (done_y),
        .o_result (res_y)
    );

    // result register; out-of-range words carry zeros
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_point.point_x     <= r_job.valid ? res_x : '0;
            r_point.point_y     <= r_job.valid ? res_y : '0;
            r_point.point_z     <= r_job.valid ? r_job.depth : '0;
            r_point.red_out     <= r_job.valid ? r_job.red : '0;
            r_point.green_out   <= r_job.valid ? r_job.green : '0;
            r_point.blue_out    <= r_job.valid ? r_job.blue : '0;
            r_point.point_valid <= r_job.valid;
            r_point.frame_end   <= r_job.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_pop && r_out_vld) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_empty = !r_out_vld;
    assign o_point = r_point;

    // both dividers run in lock step
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_x == done_y)
        else $error("x and y dividers out of step");

endmodule

>>> rtl/depth_pixel_backprojection_unit.sv
// ---------------------------------------------------------------------------
// depth_pixel_backprojection_unit : pinhole back-projection of depth pixels
// Turns a raster stream of depth pixels into camera-frame points with colour.
// ---------------------------------------------------------------------------
// Each word pushed in is one depth pixel (unsigned Q8.16 metres) with BGR
// colour, in raster order; frame_start forces it to row 0, column 0. Every
// pixel gives exactly one result word, in order: z = depth, x and y in signed
// Q15.16 metres (rounded to nearest, saturated), the colour, point_valid and
// frame_end. A pixel whose depth lies outside [depth_min, depth_max] gives a
// word with point_valid low and all other fields zero except frame_end.
// An in-range pixel passes through the back end in order: the job fetch, the
// offset-times-depth multiply, the divider load, the one-bit-per-cycle
// restoring dividers, and the round, clamp and register of the word. An
// out-of-range pixel skips the multiply and the dividers. The intake can
// run two pixels ahead of the back end through the job queue, and the result
// register holds one finished word while the next job is worked on.
// Registers sit on an APB port at byte address 4*index: focal_x, focal_y,
// center_x, center_y, image_width, image_height, depth_min, depth_max.
// Write them only while the block is idle. No clearing pass after reset.
// ---------------------------------------------------------------------------
module depth_pixel_backprojection_unit
    import dpb_pkg::*;
#(
    parameter int MAX_DIM         = MAX_DIM_DEF,
    parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel words in
    input  logic              push,
    output logic              full,
    input  t_pixel            i_pixel,
    // point words out
    output logic              empty,
    input  logic              pop,
    output t_point            o_point,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [FOCAL_W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [DIM_W-1:0]   r_image_width, r_image_height;
    logic [DEPTH_W-1:0] r_depth_min, r_depth_max;

    logic       cfg_wr;
    t_reg_idx   reg_idx;

    logic [FOCAL_W-1:0] focal_x_eff, focal_y_eff;

    t_job       front_job, q_job;
    logic       q_push, q_pop;
    t_jobq_stat q_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x      <= FOCAL_X_RST;
            r_focal_y      <= FOCAL_Y_RST;
            r_center_x     <= CENTER_X_RST;
            r_center_y     <= CENTER_Y_RST;
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
            r_depth_min    <= DMIN_RST;
            r_depth_max    <= DMAX_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FOCAL_X:      r_focal_x      <= pwdata[FOCAL_W-1:0];
                REG_FOCAL_Y:      r_focal_y      <= pwdata[FOCAL_W-1:0];
                REG_CENTER_X:     r_center_x     <= pwdata[FOCAL_W-1:0];
                REG_CENTER_Y:     r_center_y     <= pwdata[FOCAL_W-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[DIM_W-1:0];
                REG_DEPTH_MIN:    r_depth_min    <= pwdata[DEPTH_W-1:0];
                REG_DEPTH_MAX:    r_depth_max    <= pwdata[DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_FOCAL_X:      prdata = APB_DW'(r_focal_x);
            REG_FOCAL_Y:      prdata = APB_DW'(r_focal_y);
            REG_CENTER_X:     prdata = APB_DW'(r_center_x);
            REG_CENTER_Y:     prdata = APB_DW'(r_center_y);
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_image_height);
            REG_DEPTH_MIN:    prdata = APB_DW'(r_depth_min);
            REG_DEPTH_MAX:    prdata = APB_DW'(r_depth_max);
            default:          prdata = '0;
        endcase
    end

    // a zero focal length behaves as one
    assign focal_x_eff = (r_focal_x == '0) ? FOCAL_W'(1) : r_focal_x;
    assign focal_y_eff = (r_focal_y == '0) ? FOCAL_W'(1) : r_focal_y;

    assign full = q_stat.full;

    dpb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_pixel        (i_pixel),
        .i_q_stat       (q_stat),
        .i_center_x     (r_center_x),
        .i_center_y     (r_center_y),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_depth_min    (r_depth_min),
        .i_depth_max    (r_depth_max),
        .o_q_push       (q_push),
        .o_job          (front_job)
    );

    dpb_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    dpb_back #(
        .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_job),
        .i_q_stat  (q_stat),
        .o_job_pop (q_pop),
        .i_focal_x (focal_x_eff),
        .i_focal_y (focal_y_eff),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_point   (o_point)
    );

endmodule
